@@ src/tld_pkg.sv @@
// ----------------------------------------------------------------------------
// tld_pkg: shared types and constants for the terminal line discipline
// Item layouts, opcodes, register indexes, controller command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tld_pkg;

    localparam int BUF_DEPTH = 256;
    localparam int AW        = $clog2(BUF_DEPTH);
    localparam int CW        = AW + 1;
    localparam int NW        = AW + 2;
    localparam int MAX_RES   = 4;

    localparam logic [1:0] OP_RX   = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_TX   = 2'd2;
    localparam logic [1:0] OP_RSVD = 2'd3;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_ERASE = 2'd2;

    localparam logic [2:0] REG_IMODE = 3'd0;
    localparam logic [2:0] REG_LMODE = 3'd1;
    localparam logic [2:0] REG_OMODE = 3'd2;
    localparam logic [2:0] REG_SIG   = 3'd3;
    localparam logic [2:0] REG_EDIT  = 3'd4;
    localparam logic [2:0] REG_FLOW  = 3'd5;
    localparam logic [2:0] REG_ALT   = 3'd6;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CTL_OFS  = 8'h40;
    localparam logic [7:0] STRIP_M  = 8'h7F;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [8:0] erase_cells;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_eof;
        logic       write_blocked;
        logic [7:0] cursor_column;
        logic       last;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_PUT, S_PEOF, S_PEM, S_TWB, S_EDO, S_ERUN,
        S_KRD, S_KACC, S_WRD, S_WCHK, S_NRD, S_NWR, S_FIN
    } t_state;

    typedef enum logic [2:0] {
        PS_CR, PS_NL, PS_CARET, PS_CTLX, PS_CHAR, PS_DATA
    } t_psel;

    typedef enum logic [3:0] {
        CL_STOP, CL_START, CL_DROP, CL_SIG, CL_RAW, CL_EOF,
        CL_ERASE, CL_KILL, CL_WERASE, CL_NORM
    } t_cls;

    typedef struct packed {
        logic  latch;
        logic  put;
        t_psel psel;
        logic  erase;
        logic  emit_rd;
        logic  emit_eof;
        logic  emit_wb;
        logic  finish;
        logic  eof_set;
        logic  eof_clr;
        logic  stop_set;
        logic  stop_clr;
        logic  ring_rd;
        logic  push_c;
        logic  push_ls;
        logic  ls_wr;
        logic  ls_rd;
        logic  ls_at_len;
        logic  len_dec;
        logic  len_clr;
        logic  idx_clr;
        logic  idx_inc;
        logic  cells_clr;
        logic  cells_inc;
        logic  cells_acc;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        t_cls       cls;
        logic       sig_lt2;
        logic [6:0] lm;
        logic       onlcr;
        logic       c_nl;
        logic       c_ctl;
        logic       data_nl;
        logic       ring_full;
        logic       ring_empty;
        logic       eof;
        logic       stopped;
        logic       len_zero;
        logic       len_full;
        logic       idx_lt_len;
        logic       ls_blank;
        logic       cells_zero;
        logic       slot_free;
    } t_stat;

endpackage

`default_nettype wire

@@ src/tld_ctrl.sv @@
// ----------------------------------------------------------------------------
// tld_ctrl: sequencing state machine
// Steps each item through decode, echo byte lists, buffer walks and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module tld_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire tld_pkg::t_stat i_st,
    output tld_pkg::t_cmd      o_cmd
);
    import tld_pkg::*;

    t_state     r_state, n_state;
    t_state     r_after, n_after;
    t_psel      r_q [3];
    t_psel      n_q [3];
    logic [1:0] r_qn, n_qn;
    logic       r_crdone, n_crdone;
    logic       r_phase, n_phase;

    t_psel      ep0, ep1;
    logic [1:0] epn;
    logic       hnl;
    logic       echo, echoe, echok, echoctl, echoke, canon;

    assign echo    = i_st.lm[2];
    assign echoe   = i_st.lm[3];
    assign echok   = i_st.lm[4];
    assign echoctl = i_st.lm[5];
    assign echoke  = i_st.lm[6];
    assign canon   = i_st.lm[1];

    assign o_in_stall = (r_state != S_IDLE);

    // echo byte list for the current character
    always_comb begin
        ep0 = PS_CHAR;
        ep1 = PS_CTLX;
        epn = 2'd0;
        if (echo) begin
            if (i_st.c_nl) begin
                ep0 = PS_NL;
                epn = 2'd1;
            end else if (i_st.c_ctl && echoctl) begin
                ep0 = PS_CARET;
                epn = 2'd2;
            end else begin
                epn = 2'd1;
            end
        end
    end

    assign hnl = (r_q[0] == PS_NL) || ((r_q[0] == PS_CHAR) && i_st.c_nl)
              || ((r_q[0] == PS_DATA) && i_st.data_nl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_after  <= S_FIN;
            r_qn     <= 2'd0;
            r_crdone <= 1'b0;
            r_phase  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_after  <= n_after;
            r_qn     <= n_qn;
            r_crdone <= n_crdone;
            r_phase  <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_after  = r_after;
        n_q      = r_q;
        n_qn     = r_qn;
        n_crdone = r_crdone;
        n_phase  = r_phase;
        case (r_state)
            S_IDLE: begin
                n_crdone = 1'b0;
                n_phase  = 1'b0;
                if (i_in_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_FIN;
                n_after = S_FIN;
                case (i_st.op)
                    OP_RX: begin
                        case (i_st.cls)
                            CL_SIG: begin
                                n_state = S_PUT;
                                n_q[0]  = ep0;
                                n_q[1]  = ep1;
                                n_q[2]  = PS_NL;
                                if (epn == 2'd0) begin
                                    n_q[0] = PS_NL;
                                end else if (epn == 2'd1) begin
                                    n_q[1] = PS_NL;
                                end
                                n_qn = epn + 2'd1;
                            end
                            CL_RAW: begin
                                if (!i_st.ring_full && echo) begin
                                    n_state = S_PUT;
                                    n_q[0]  = PS_CHAR;
                                    n_qn    = 2'd1;
                                end
                            end
                            CL_ERASE: begin
                                if (!i_st.len_zero) begin
                                    n_state = S_EDO;
                                end
                            end
                            CL_KILL: begin
                                if (echoke) begin
                                    n_state = S_KRD;
                                end else if (echok) begin
                                    n_state = S_PUT;
                                    n_q[0]  = PS_NL;
                                    n_qn    = 2'd1;
                                end
                            end
                            CL_WERASE: begin
                                n_state = S_WRD;
                            end
                            CL_NORM: begin
                                n_after = i_st.c_nl ? S_NRD : S_FIN;
                                n_state = i_st.c_nl ? S_NRD : S_FIN;
                                if (!i_st.len_full && (epn != 2'd0)) begin
                                    n_state = S_PUT;
                                    n_q[0]  = ep0;
                                    n_q[1]  = ep1;
                                    n_qn    = epn;
                                end
                            end
                            default: n_state = S_FIN;
                        endcase
                    end
                    OP_POP: begin
                        if (canon && i_st.ring_empty && i_st.eof) begin
                            n_state = S_PEOF;
                        end else if (!i_st.ring_empty) begin
                            n_state = S_PEM;
                        end
                    end
                    OP_TX: begin
                        if (i_st.stopped) begin
                            n_state = S_TWB;
                        end else begin
                            n_state = S_PUT;
                            n_q[0]  = PS_DATA;
                            n_qn    = 2'd1;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_PUT: begin
                if (i_st.slot_free) begin
                    if (i_st.onlcr && hnl && !r_crdone) begin
                        n_crdone = 1'b1;
                    end else begin
                        n_crdone = 1'b0;
                        n_q[0]   = r_q[1];
                        n_q[1]   = r_q[2];
                        n_qn     = r_qn - 2'd1;
                        if (r_qn == 2'd1) begin
                            n_state = r_after;
                        end
                    end
                end
            end
            S_PEOF, S_PEM, S_TWB: begin
                if (i_st.slot_free) begin
                    n_state = S_FIN;
                end
            end
            S_EDO: n_state = echoe ? S_ERUN : S_FIN;
            S_ERUN: begin
                if (i_st.cells_zero || i_st.slot_free) begin
                    n_state = S_FIN;
                end
            end
            S_KRD: n_state = i_st.idx_lt_len ? S_KACC : S_ERUN;
            S_KACC: n_state = S_KRD;
            S_WRD: begin
                if (i_st.len_zero) begin
                    n_state = echoe ? S_ERUN : S_FIN;
                end else begin
                    n_state = S_WCHK;
                end
            end
            S_WCHK: begin
                if (!r_phase && i_st.ls_blank) begin
                    n_state = S_WRD;
                end else if (!i_st.ls_blank) begin
                    n_phase = 1'b1;
                    n_state = S_WRD;
                end else begin
                    n_state = echoe ? S_ERUN : S_FIN;
                end
            end
            S_NRD: n_state = i_st.idx_lt_len ? S_NWR : S_FIN;
            S_NWR: n_state = S_NRD;
            S_FIN: begin
                if (i_st.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.psel = PS_CHAR;
        case (r_state)
            S_IDLE: o_cmd.latch = i_in_valid;
            S_DISP: begin
                case (i_st.op)
                    OP_RX: begin
                        case (i_st.cls)
                            CL_STOP:  o_cmd.stop_set = 1'b1;
                            CL_START: o_cmd.stop_clr = 1'b1;
                            CL_SIG:   o_cmd.len_clr  = i_st.sig_lt2;
                            CL_RAW:   o_cmd.push_c   = !i_st.ring_full;
                            CL_EOF:   o_cmd.eof_set  = 1'b1;
                            CL_ERASE: begin
                                o_cmd.cells_clr = 1'b1;
                                if (!i_st.len_zero) begin
                                    o_cmd.ls_rd     = 1'b1;
                                    o_cmd.ls_at_len = 1'b1;
                                    o_cmd.len_dec   = 1'b1;
                                end
                            end
                            CL_KILL: begin
                                o_cmd.cells_clr = 1'b1;
                                o_cmd.idx_clr   = 1'b1;
                                o_cmd.len_clr   = !echoke;
                            end
                            CL_WERASE: o_cmd.cells_clr = 1'b1;
                            CL_NORM: begin
                                o_cmd.idx_clr = 1'b1;
                                o_cmd.ls_wr   = !i_st.len_full;
                            end
                            default: o_cmd.cells_clr = 1'b0;
                        endcase
                    end
                    OP_POP: begin
                        if (!(canon && i_st.ring_empty && i_st.eof)) begin
                            o_cmd.ring_rd = !i_st.ring_empty;
                        end
                    end
                    default: o_cmd.ring_rd = 1'b0;
                endcase
            end
            S_PUT: begin
                if (i_st.slot_free) begin
                    o_cmd.put  = 1'b1;
                    o_cmd.psel = (i_st.onlcr && hnl && !r_crdone) ? PS_CR : r_q[0];
                end
            end
            S_PEOF: begin
                o_cmd.emit_eof = i_st.slot_free;
                o_cmd.eof_clr  = i_st.slot_free;
            end
            S_PEM:  o_cmd.emit_rd = i_st.slot_free;
            S_TWB:  o_cmd.emit_wb = i_st.slot_free;
            S_EDO:  o_cmd.cells_acc = 1'b1;
            S_ERUN: o_cmd.erase = i_st.slot_free && !i_st.cells_zero;
            S_KRD: begin
                o_cmd.ls_rd   = i_st.idx_lt_len;
                o_cmd.len_clr = !i_st.idx_lt_len;
            end
            S_KACC: begin
                o_cmd.cells_acc = 1'b1;
                o_cmd.idx_inc   = 1'b1;
            end
            S_WRD: begin
                o_cmd.ls_rd     = !i_st.len_zero;
                o_cmd.ls_at_len = 1'b1;
            end
            S_WCHK: begin
                if ((!r_phase && i_st.ls_blank) || !i_st.ls_blank) begin
                    o_cmd.len_dec   = 1'b1;
                    o_cmd.cells_inc = 1'b1;
                end
            end
            S_NRD: begin
                o_cmd.ls_rd   = i_st.idx_lt_len;
                o_cmd.len_clr = !i_st.idx_lt_len;
            end
            S_NWR: begin
                o_cmd.push_ls = !i_st.ring_full;
                o_cmd.idx_inc = 1'b1;
            end
            S_FIN:  o_cmd.finish = i_st.slot_free;
            default: o_cmd.finish = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

@@ src/tld_dp.sv @@
// ----------------------------------------------------------------------------
// tld_dp: line discipline datapath
// Config registers, input decode, read ring, line store, column, result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module tld_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire tld_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output tld_pkg::t_out_item      o_out_item,
    input  wire tld_pkg::t_cmd      i_cmd,
    output tld_pkg::t_stat          o_st
);
    import tld_pkg::*;

    logic [4:0]  r_im;
    logic [6:0]  r_lm;
    logic [1:0]  r_om;
    logic [23:0] r_sc;
    logic [31:0] r_ec;
    logic [15:0] r_fc;
    logic [7:0]  r_alt;

    logic [7:0]  r_ring [BUF_DEPTH];
    logic [7:0]  r_ls   [BUF_DEPTH];
    logic [7:0]  r_rdata, r_lsdata;
    logic [AW-1:0] r_head, r_tail, r_len, r_idx;
    logic [CW-1:0] r_cnt;
    logic        r_stop, r_eof;
    logic [7:0]  r_col, n_col;
    logic [NW-1:0] r_cells;

    logic [1:0]  r_op;
    logic [7:0]  r_byte;

    logic        r_ovalid, r_pvalid;
    t_out_item   r_out, r_pend, ev, fin_item;
    logic [2:0]  r_rcnt;
    logic        slot_free, ev_valid;

    logic [7:0]  c1, c, pb, push_byte;
    t_cls        cls;
    logic        sig_lt2;
    logic [AW-1:0] ls_addr;
    logic [8:0]  tab;
    logic        lsd_ctl;

    // input decode
    always_comb begin
        c1      = r_im[1] ? (r_byte & STRIP_M) : r_byte;
        c       = c1;
        cls     = CL_NORM;
        sig_lt2 = 1'b0;
        if (r_im[0] && (r_byte == r_fc[15:8])) begin
            cls = CL_STOP;
        end else if (r_im[0] && (r_byte == r_fc[7:0])) begin
            cls = CL_START;
        end else if ((c1 == CH_CR) && r_im[2]) begin
            cls = CL_DROP;
        end else begin
            if ((c1 == CH_CR) && r_im[3]) begin
                c = CH_NL;
            end else if ((c1 == CH_NL) && r_im[4]) begin
                c = CH_CR;
            end
            if (r_lm[0] && ((c == r_sc[7:0]) || (c == r_sc[15:8]))) begin
                cls     = CL_SIG;
                sig_lt2 = 1'b1;
            end else if (r_lm[0] && (c == r_sc[23:16])) begin
                cls = CL_SIG;
            end else if (!r_lm[1]) begin
                cls = CL_RAW;
            end else if (c == r_ec[7:0]) begin
                cls = CL_EOF;
            end else if ((c == r_ec[15:8]) || (c == r_alt)) begin
                cls = CL_ERASE;
            end else if (c == r_ec[23:16]) begin
                cls = CL_KILL;
            end else if (c == r_ec[31:24]) begin
                cls = CL_WERASE;
            end
        end
    end

    always_comb begin
        case (i_cmd.psel)
            PS_CR:    pb = CH_CR;
            PS_NL:    pb = CH_NL;
            PS_CARET: pb = CH_CARET;
            PS_CTLX:  pb = c + CTL_OFS;
            PS_DATA:  pb = r_byte;
            default:  pb = c;
        endcase
    end

    assign tab     = ({1'b0, r_col} + 9'd8) & 9'h1F8;
    assign lsd_ctl = (r_lsdata < CH_SP) && (r_lsdata != CH_TAB) && r_lm[5];

    always_comb begin
        n_col = r_col;
        if (i_cmd.put) begin
            if ((pb == CH_NL) || (pb == CH_CR)) begin
                n_col = 8'd0;
            end else if (pb == CH_TAB) begin
                n_col = tab[8] ? 8'hFF : tab[7:0];
            end else if (pb >= CH_SP) begin
                n_col = (r_col == 8'hFF) ? r_col : r_col + 8'd1;
            end else if ((pb == CH_BS) && (r_col != 8'd0)) begin
                n_col = r_col - 8'd1;
            end
        end else if (i_cmd.erase) begin
            n_col = (NW'(r_col) > r_cells) ? (r_col - r_cells[7:0]) : 8'd0;
        end
    end

    always_comb begin
        ev               = '0;
        ev.cursor_column = n_col;
        if (i_cmd.put) begin
            ev.out_kind = KIND_BYTE;
            ev.out_byte = pb;
        end else if (i_cmd.erase) begin
            ev.out_kind    = KIND_ERASE;
            ev.erase_cells = (r_cells > NW'(511)) ? 9'd511 : r_cells[8:0];
        end
        ev.read_valid    = i_cmd.emit_rd;
        ev.read_byte     = i_cmd.emit_rd ? r_rdata : 8'd0;
        ev.read_eof      = i_cmd.emit_eof;
        ev.write_blocked = i_cmd.emit_wb;
    end

    // final item of a step: the pending result, or an empty one
    always_comb begin
        fin_item = r_pend;
        if (!r_pvalid) begin
            fin_item               = '0;
            fin_item.cursor_column = r_col;
        end
        fin_item.last = 1'b1;
    end

    assign ev_valid  = (i_cmd.put || i_cmd.erase || i_cmd.emit_rd || i_cmd.emit_eof
                     || i_cmd.emit_wb) && (r_rcnt < 3'(MAX_RES));
    assign slot_free = !r_ovalid || !i_out_stall;
    assign ls_addr   = i_cmd.ls_at_len ? (r_len - AW'(1)) : r_idx;
    assign push_byte = i_cmd.push_ls ? r_lsdata : c;

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_c || i_cmd.push_ls) begin
            r_ring[r_tail] <= push_byte;
        end
        if (i_cmd.ring_rd) begin
            r_rdata <= r_ring[r_head];
        end
        if (i_cmd.ls_wr) begin
            r_ls[r_len] <= c;
        end
        if (i_cmd.ls_rd) begin
            r_lsdata <= r_ls[ls_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_in_item.opcode;
            r_byte <= i_in_item.data_byte;
        end
        if (ev_valid && r_pvalid) begin
            r_out <= r_pend;
        end else if (i_cmd.finish) begin
            r_out <= fin_item;
        end
        if (ev_valid) begin
            r_pend <= ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_im     <= 5'd9;
            r_lm     <= 7'd127;
            r_om     <= 2'd3;
            r_sc     <= 24'h1A1C03;
            r_ec     <= 32'h17157F04;
            r_fc     <= 16'h1311;
            r_alt    <= 8'h08;
            r_head   <= '0;
            r_tail   <= '0;
            r_cnt    <= '0;
            r_len    <= '0;
            r_idx    <= '0;
            r_cells  <= '0;
            r_stop   <= 1'b0;
            r_eof    <= 1'b0;
            r_col    <= 8'd0;
            r_ovalid <= 1'b0;
            r_pvalid <= 1'b0;
            r_rcnt   <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_IMODE: r_im  <= i_cfg_data[4:0];
                    REG_LMODE: r_lm  <= i_cfg_data[6:0];
                    REG_OMODE: r_om  <= i_cfg_data[1:0];
                    REG_SIG:   r_sc  <= i_cfg_data[23:0];
                    REG_EDIT:  r_ec  <= i_cfg_data;
                    REG_FLOW:  r_fc  <= i_cfg_data[15:0];
                    REG_ALT:   r_alt <= i_cfg_data[7:0];
                    default:   r_alt <= r_alt;
                endcase
            end
            if (i_cmd.push_c || i_cmd.push_ls) begin
                r_tail <= (r_tail == AW'(BUF_DEPTH - 1)) ? '0 : r_tail + AW'(1);
                r_cnt  <= r_cnt + CW'(1);
            end else if (i_cmd.ring_rd) begin
                r_head <= (r_head == AW'(BUF_DEPTH - 1)) ? '0 : r_head + AW'(1);
                r_cnt  <= r_cnt - CW'(1);
            end
            if (i_cmd.ls_wr) begin
                r_len <= r_len + AW'(1);
            end else if (i_cmd.len_dec) begin
                r_len <= r_len - AW'(1);
            end else if (i_cmd.len_clr) begin
                r_len <= '0;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + AW'(1);
            end
            if (i_cmd.cells_clr) begin
                r_cells <= '0;
            end else if (i_cmd.cells_inc) begin
                r_cells <= r_cells + NW'(1);
            end else if (i_cmd.cells_acc) begin
                r_cells <= r_cells + (lsd_ctl ? NW'(2) : NW'(1));
            end
            if (i_cmd.stop_set) begin
                r_stop <= 1'b1;
            end else if (i_cmd.stop_clr) begin
                r_stop <= 1'b0;
            end
            if (i_cmd.eof_set) begin
                r_eof <= 1'b1;
            end else if (i_cmd.eof_clr) begin
                r_eof <= 1'b0;
            end
            r_col <= n_col;
            if (ev_valid) begin
                r_pvalid <= 1'b1;
                r_rcnt   <= r_rcnt + 3'd1;
                r_ovalid <= r_pvalid ? 1'b1 : (r_ovalid && i_out_stall);
            end else if (i_cmd.finish) begin
                r_pvalid <= 1'b0;
                r_rcnt   <= 3'd0;
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    always_comb begin
        o_st            = '0;
        o_st.op         = r_op;
        o_st.cls        = cls;
        o_st.sig_lt2    = sig_lt2;
        o_st.lm         = r_lm;
        o_st.onlcr      = r_om[0] && r_om[1];
        o_st.c_nl       = (c == CH_NL);
        o_st.c_ctl      = (c < CH_SP) && (c != CH_TAB);
        o_st.data_nl    = (r_byte == CH_NL);
        o_st.ring_full  = (r_cnt == CW'(BUF_DEPTH));
        o_st.ring_empty = (r_cnt == '0);
        o_st.eof        = r_eof;
        o_st.stopped    = r_stop;
        o_st.len_zero   = (r_len == '0);
        o_st.len_full   = (r_len == AW'(BUF_DEPTH - 1));
        o_st.idx_lt_len = (r_idx < r_len);
        o_st.ls_blank   = (r_lsdata == CH_SP) || (r_lsdata == CH_TAB);
        o_st.cells_zero = (r_cells == '0);
        o_st.slot_free  = slot_free;
    end

endmodule

`default_nettype wire

@@ src/terminal_line_discipline_top.sv @@
// ----------------------------------------------------------------------------
// terminal_line_discipline_top: terminal line discipline
// One item at a time: the input stalls until the current item has finished.
// Newline transfer, kill with echoke and word erase walk the line store
// one stored byte at a time (single-port store read).
// Synchronous active-low reset restores the register defaults and empties
// the ring and line; no clearing pass, store contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_line_discipline_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire tld_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output tld_pkg::t_out_item      o_out_item,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data
);
    import tld_pkg::*;

    t_cmd  cmd;
    t_stat st;

    tld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    tld_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cmd       (cmd),
        .o_st        (st)
    );

endmodule

`default_nettype wire

@@ tb/tb_terminal_line_discipline_top.sv @@
// ----------------------------------------------------------------------------
// tb_terminal_line_discipline_top: self-checking bench for the line discipline
// Drives receive, pop and transmit items under random idling on both sides,
// predicts every output item with a behavioral model of the discipline, and
// compares each output item in order. Several register settings are covered.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_terminal_line_discipline_top;
    import tld_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    in_item = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [31:0] cfg_data = '0;

    terminal_line_discipline_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // discipline state mirror
    int          imode = 9, lmode = 127, omode = 3;
    logic [23:0] sig_chars = 24'h1A1C03;
    logic [31:0] edit_chars = 32'h17157F04;
    logic [15:0] flow_chars = 16'h1311;
    logic [7:0]  alt_erase = 8'h08;
    logic [7:0]  read_ring [BUF_DEPTH];
    logic [7:0]  line_store [BUF_DEPTH];
    int          ring_head = 0, ring_tail = 0, ring_count = 0, line_len = 0;
    bit          stopped = 0, eof_flag = 0;
    int          column = 0;

    t_out_item   step_items[$];
    t_out_item   expected_items[$];
    int          mismatches = 0;
    bit          quiet = 0;
    int          hold_cycles = 0;
    int          idle_count = 0;

    function automatic void emit(int kind, int ch, int cells, int rv, int rb, int reof, int wb);
        t_out_item r;
        if (step_items.size() >= MAX_RES) return;
        r = '0;
        r.out_kind      = kind[1:0];
        r.out_byte      = ch[7:0];
        r.erase_cells   = cells[8:0];
        r.read_valid    = rv[0];
        r.read_byte     = rb[7:0];
        r.read_eof      = reof[0];
        r.write_blocked = wb[0];
        r.cursor_column = column[7:0];
        step_items.push_back(r);
    endfunction

    function automatic void put_char(int c);
        c = c & 8'hFF;
        if (omode[0] && omode[1] && c == CH_NL) begin
            column = 0;
            emit(KIND_BYTE, CH_CR, 0, 0, 0, 0, 0);
        end
        if (c == CH_NL || c == CH_CR) column = 0;
        else if (c == CH_TAB) column = ((column + 8) & ~7) > 255 ? 255 : ((column + 8) & ~7);
        else if (c >= CH_SP) begin
            if (column < 255) column++;
        end else if (c == CH_BS && column > 0) column--;
        emit(KIND_BYTE, c, 0, 0, 0, 0, 0);
    endfunction

    function automatic void erase_cells_out(int n);
        if (n == 0) return;
        column = column > n ? column - n : 0;
        emit(KIND_ERASE, 0, n > 511 ? 511 : n, 0, 0, 0, 0);
    endfunction

    function automatic bit is_ctl(int c);
        return c < CH_SP && c != CH_TAB;
    endfunction

    function automatic bit is_blank(int c);
        return c == CH_SP || c == CH_TAB;
    endfunction

    function automatic void echo_char(int c);
        if (!lmode[2]) return;
        if (c == CH_NL) put_char(CH_NL);
        else if (is_ctl(c) && lmode[5]) begin
            put_char(CH_CARET);
            put_char(c + CTL_OFS);
        end else put_char(c);
    endfunction

    function automatic bit ring_push(int c);
        if (ring_count >= BUF_DEPTH) return 0;
        read_ring[ring_tail] = c[7:0];
        ring_tail = (ring_tail + 1) % BUF_DEPTH;
        ring_count++;
        return 1;
    endfunction

    function automatic void receive_char(int c);
        int i;
        int n;
        int e;
        if (imode[0]) begin
            if (c == flow_chars[15:8]) begin stopped = 1; return; end
            if (c == flow_chars[7:0]) begin stopped = 0; return; end
        end
        if (imode[1]) c = c & STRIP_M;
        if (c == CH_CR) begin
            if (imode[2]) return;
            if (imode[3]) c = CH_NL;
        end else if (c == CH_NL && imode[4]) c = CH_CR;
        if (lmode[0]) begin
            for (i = 0; i < 3; i++) begin
                if (c == sig_chars[8*i +: 8]) begin
                    echo_char(c);
                    put_char(CH_NL);
                    if (i < 2) line_len = 0;
                    return;
                end
            end
        end
        if (!lmode[1]) begin
            if (ring_push(c) && lmode[2]) put_char(c);
            return;
        end
        if (c == edit_chars[7:0]) begin eof_flag = 1; return; end
        if (c == edit_chars[15:8] || c == alt_erase) begin
            if (line_len > 0) begin
                line_len--;
                e = line_store[line_len];
                n = (is_ctl(e) && lmode[5]) ? 2 : 1;
                if (lmode[3]) erase_cells_out(n);
            end
            return;
        end
        if (c == edit_chars[23:16]) begin
            if (lmode[6]) begin
                n = 0;
                for (i = 0; i < line_len; i++)
                    n += (is_ctl(line_store[i]) && lmode[5]) ? 2 : 1;
                erase_cells_out(n);
            end else if (lmode[4]) put_char(CH_NL);
            line_len = 0;
            return;
        end
        if (c == edit_chars[31:24]) begin
            n = 0;
            while (line_len > 0 && is_blank(line_store[line_len-1])) begin
                line_len--; n++;
            end
            while (line_len > 0 && !is_blank(line_store[line_len-1])) begin
                line_len--; n++;
            end
            if (lmode[3]) erase_cells_out(n);
            return;
        end
        if (line_len < BUF_DEPTH - 1) begin
            line_store[line_len] = c[7:0];
            line_len++;
            echo_char(c);
        end
        if (c == CH_NL) begin
            for (i = 0; i < line_len; i++) void'(ring_push(line_store[i]));
            line_len = 0;
        end
    endfunction

    function automatic void predict_item(logic [1:0] op, logic [7:0] ch);
        step_items.delete();
        if (op == OP_RX) receive_char(ch);
        else if (op == OP_POP) begin
            if (lmode[1] && ring_count == 0 && eof_flag) begin
                eof_flag = 0;
                emit(KIND_NONE, 0, 0, 0, 0, 1, 0);
            end else if (ring_count > 0) begin
                emit(KIND_NONE, 0, 0, 1, read_ring[ring_head], 0, 0);
                ring_head = (ring_head + 1) % BUF_DEPTH;
                ring_count--;
            end
        end else if (op == OP_TX) begin
            if (stopped) emit(KIND_NONE, 0, 0, 0, 0, 0, 1);
            else put_char(ch);
        end
        if (step_items.size() == 0) emit(KIND_NONE, 0, 0, 0, 0, 0, 0);
        step_items[step_items.size()-1].last = 1'b1;
        foreach (step_items[k]) expected_items.push_back(step_items[k]);
    endfunction

    function automatic string show(t_out_item r);
        return $sformatf("kind=%0d byte=%h cells=%0d rv=%0d rb=%h eof=%0d wb=%0d col=%0d last=%0d",
                         r.out_kind, r.out_byte, r.erase_cells, r.read_valid, r.read_byte,
                         r.read_eof, r.write_blocked, r.cursor_column, r.last);
    endfunction

    // output checker
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_items.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item: %s", show(o_out_item));
            end else begin
                e = expected_items.pop_front();
                if (o_out_item.out_kind !== e.out_kind || o_out_item.out_byte !== e.out_byte ||
                    o_out_item.erase_cells !== e.erase_cells ||
                    o_out_item.read_valid !== e.read_valid ||
                    o_out_item.read_byte !== e.read_byte || o_out_item.read_eof !== e.read_eof ||
                    o_out_item.write_blocked !== e.write_blocked ||
                    o_out_item.cursor_column !== e.cursor_column ||
                    o_out_item.last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch expected: %s", show(e));
                        $display("         actual:   %s", show(o_out_item));
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stall bursts
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (quiet) begin
                out_stall <= 1'b0;
                @(posedge i_clk);
            end else if (hold_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 16) * ($urandom_range(0, 5) == 0 ? 4 : 1))
                    @(posedge i_clk);
            end
        end
    end

    task automatic send_item(logic [1:0] op, logic [7:0] ch);
        in_item  <= '{opcode: op, data_byte: ch};
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_item(op, ch);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_items.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_IMODE: imode = val[4:0];
            REG_LMODE: lmode = val[6:0];
            REG_OMODE: omode = val[1:0];
            REG_SIG:   sig_chars = val[23:0];
            REG_EDIT:  edit_chars = val;
            REG_FLOW:  flow_chars = val[15:0];
            REG_ALT:   alt_erase = val[7:0];
            default: ;
        endcase
    endtask

    function automatic logic [7:0] pick_char();
        logic [7:0] pool[16];
        pool = '{edit_chars[7:0], edit_chars[15:8], edit_chars[23:16], edit_chars[31:24],
                 sig_chars[7:0], sig_chars[15:8], sig_chars[23:16], flow_chars[7:0],
                 flow_chars[15:8], alt_erase, CH_CR, CH_NL, CH_TAB, CH_SP, CH_BS, 8'hE1};
        case ($urandom_range(0, 9))
            0, 1, 2: return pool[$urandom_range(0, 15)];
            3, 4:    return 8'h61 + 8'($urandom_range(0, 25));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_items(int count);
        int r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 60) send_item(OP_RX, pick_char());
            else if (r < 84) send_item(OP_POP, 8'($urandom_range(0, 255)));
            else if (r < 97) send_item(OP_TX, pick_char());
            else send_item(OP_RSVD, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_directed();
        send_item(OP_RX, 8'h61);
        send_item(OP_RX, 8'hFF);
        send_item(OP_RX, 8'h00);
        send_item(OP_RX, 8'h01);
        send_item(OP_RX, 8'h7F);
        send_item(OP_RX, CH_BS);
        send_item(OP_RX, 8'h77);
        send_item(OP_RX, CH_SP);
        send_item(OP_RX, 8'h17);
        send_item(OP_RX, CH_TAB);
        send_item(OP_RX, 8'h15);
        send_item(OP_RX, 8'h7A);
        send_item(OP_RX, CH_CR);
        send_item(OP_POP, 8'h00);
        send_item(OP_POP, 8'hFF);
        send_item(OP_RX, 8'h04);
        send_item(OP_POP, 8'h00);
        send_item(OP_POP, 8'h00);
        send_item(OP_RX, 8'h03);
        send_item(OP_RX, 8'h13);
        send_item(OP_TX, 8'h78);
        send_item(OP_RX, 8'h11);
        send_item(OP_TX, CH_TAB);
        send_item(OP_TX, CH_BS);
        send_item(OP_RSVD, 8'h55);
    endtask

    task automatic test_long_line();
        repeat (256) send_item(OP_RX, 8'h41 + 8'($urandom_range(0, 25)));
        send_item(OP_RX, CH_CR);
        write_reg(REG_LMODE, 32'h7D);
        repeat (3) send_item(OP_RX, 8'h30);
        write_reg(REG_LMODE, 32'h7F);
    endtask

    task automatic test_back_pressure();
        drain();
        hold_cycles = 600;
        repeat (30) send_item(OP_POP, 8'h00);
    endtask

    task automatic test_settings();
        write_reg(REG_IMODE, 32'h1F);
        write_reg(REG_OMODE, 32'h0);
        write_reg(REG_ALT, 32'hFF);
        random_items(30);
        write_reg(REG_IMODE, 32'h0);
        write_reg(REG_LMODE, 32'h0);
        write_reg(REG_OMODE, 32'h1);
        random_items(30);
        write_reg(REG_IMODE, 32'h2);
        write_reg(REG_LMODE, 32'h2E);
        write_reg(REG_SIG, 32'hFFFFFF);
        write_reg(REG_EDIT, 32'hFFFFFFFF);
        write_reg(REG_FLOW, 32'hFFFF);
        random_items(20);
        write_reg(REG_LMODE, 32'h16);
        write_reg(REG_SIG, 32'h0);
        write_reg(REG_EDIT, 32'h0);
        write_reg(REG_FLOW, 32'h0);
        write_reg(REG_ALT, 32'h0);
        random_items(20);
        write_reg(REG_IMODE, 32'($urandom_range(0, 31)));
        write_reg(REG_LMODE, 32'($urandom_range(0, 127)));
        write_reg(REG_SIG, {8'h0, 24'($urandom)});
        write_reg(REG_EDIT, $urandom);
        write_reg(REG_FLOW, 32'($urandom_range(0, 65535)));
        random_items(20);
    endtask

    task automatic test_defaults_quiet();
        write_reg(REG_IMODE, 32'd9);
        write_reg(REG_LMODE, 32'd127);
        write_reg(REG_OMODE, 32'd3);
        write_reg(REG_SIG, 32'h1A1C03);
        write_reg(REG_EDIT, 32'h17157F04);
        write_reg(REG_FLOW, 32'h1311);
        write_reg(REG_ALT, 32'h08);
        quiet = 1;
        random_items(30);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_long_line();
        test_back_pressure();
        test_settings();
        test_defaults_quiet();
        drain();
        repeat (600) @(posedge i_clk);
        if (expected_items.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/tld_pkg.sv
src/tld_ctrl.sv
src/tld_dp.sv
src/terminal_line_discipline_top.sv
tb/tb_terminal_line_discipline_top.sv
